@@ rtl/assert_macros.svh @@
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while in reset
`define PM_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pmac assertion failed");

// clocked assertion, also checked during reset
`define PM_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) else $error("pmac assertion failed");

`endif

@@ rtl/pmac_pkg.sv @@
// types, op codes and clamp helpers for the poly1305 mac engine
// no dependencies
package pmac_pkg;

  typedef struct packed {
    logic [63:0] data_low;
    logic [63:0] data_high;
    logic [4:0]  byte_count;
    logic        last;
  } in_t;

  typedef struct packed {
    logic [63:0] tag_low;
    logic [63:0] tag_high;
  } out_t;

  typedef struct packed {
    logic [63:0] r_low;
    logic [63:0] r_high;
    logic [63:0] s_low;
    logic [63:0] s_high;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ADD,
    OP_MUL,
    OP_D4,
    OP_RED,
    OP_FOLD,
    OP_SEL,
    OP_TAG
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] i;
    logic [2:0] j;
  } cmd_t;

  typedef struct packed {
    logic nz;
    logic last;
  } stat_t;

  localparam logic [1:0] REG_R_LOW  = 2'd0;
  localparam logic [1:0] REG_R_HIGH = 2'd1;
  localparam logic [1:0] REG_S_LOW  = 2'd2;
  localparam logic [1:0] REG_S_HIGH = 2'd3;

  localparam logic [31:0] CLAMP_LO = 32'h0fffffff;
  localparam logic [31:0] CLAMP_HI = 32'h0ffffffc;

  localparam logic [2:0] LIMB_TOP = 3'd4;

  // 5 * (r >> 2), using that the low two bits are dropped
  function automatic logic [31:0] times5q(input logic [31:0] r);
    times5q = {r[31:2], 2'b00} + {2'b00, r[31:2]};
  endfunction

endpackage

@@ rtl/pmac_regs.sv @@
// apb register file for the key halves r and s
// depends on pmac_pkg
module pmac_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  output pmac_pkg::cfg_t      cfg_o
);

  pmac_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[4:3])
        pmac_pkg::REG_R_LOW:  cfg_d.r_low  = pwdata;
        pmac_pkg::REG_R_HIGH: cfg_d.r_high = pwdata;
        pmac_pkg::REG_S_LOW:  cfg_d.s_low  = pwdata;
        pmac_pkg::REG_S_HIGH: cfg_d.s_high = pwdata;
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      pmac_pkg::REG_R_LOW:  prdata = cfg_q.r_low;
      pmac_pkg::REG_R_HIGH: prdata = cfg_q.r_high;
      pmac_pkg::REG_S_LOW:  prdata = cfg_q.s_low;
      pmac_pkg::REG_S_HIGH: prdata = cfg_q.s_high;
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/pmac_dp.sv @@
// datapath: accumulator, shared 32x32 multiplier, carry pass and tag finish
// depends on pmac_pkg
module pmac_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pmac_pkg::in_t    in_i,
  input  pmac_pkg::cfg_t   cfg_i,
  input  pmac_pkg::cmd_t   cmd_i,
  output pmac_pkg::stat_t  stat_o,
  output pmac_pkg::out_t   tag_o
);

  logic [159:0]     h_q;
  logic [159:0]     a_q;
  logic [159:0]     blk_q;
  logic [4:0][63:0] d_q;
  logic [63:0]      p_q;
  logic [2:0]       p_dst_q;
  logic             p_vld_q;
  logic [63:0]      c_q;
  logic [127:0]     tag_q;
  pmac_pkg::stat_t  stat_q;

  logic [4:0]       n_w;
  logic [127:0]     data_w;
  logic [127:0]     mask_w;
  logic [159:0]     pad_w;
  logic [3:0][31:0] r_w;
  logic [3:0][31:0] f_w;
  logic [1:0]       m_w;
  logic [31:0]      coef_w;
  logic [31:0]      alimb_w;
  logic [63:0]      prod_w;
  logic [63:0]      c_w;
  logic [159:0]     fold_w;
  logic [159:0]     g_w;

  assign n_w    = in_i.byte_count[4] ? 5'd16 : in_i.byte_count;
  assign data_w = {in_i.data_high, in_i.data_low};

  always_comb begin
    for (int b = 0; b < 16; b++) begin
      mask_w[8*b +: 8] = (5'(b) < n_w) ? 8'hff : 8'h00;
    end
  end

  assign pad_w = 160'(1) << {n_w, 3'b000};

  assign r_w[0] = cfg_i.r_low[31:0]   & pmac_pkg::CLAMP_LO;
  assign r_w[1] = cfg_i.r_low[63:32]  & pmac_pkg::CLAMP_HI;
  assign r_w[2] = cfg_i.r_high[31:0]  & pmac_pkg::CLAMP_HI;
  assign r_w[3] = cfg_i.r_high[63:32] & pmac_pkg::CLAMP_HI;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      f_w[k] = pmac_pkg::times5q(r_w[k]);
    end
  end

  // coefficient for a[i] into d[j]: r[j-i], or 5*r/4 where it wraps past 2^130; d[4] takes r[0][1:0]
  assign m_w = 2'(cmd_i.j - cmd_i.i);

  always_comb begin
    if (cmd_i.j == pmac_pkg::LIMB_TOP) begin
      coef_w = {30'b0, r_w[0][1:0]};
    end else if (cmd_i.i > cmd_i.j) begin
      coef_w = f_w[m_w];
    end else begin
      coef_w = r_w[m_w];
    end
  end

  assign alimb_w = a_q[{cmd_i.i, 5'b00000} +: 32];
  assign prod_w  = 64'(alimb_w) * 64'(coef_w);

  always_comb begin
    unique case (cmd_i.i)
      3'd0:    c_w = {d_q[4][63:2], 2'b00} + {2'b00, d_q[4][63:2]} + {32'b0, d_q[0][31:0]};
      3'd1:    c_w = c_q + {32'b0, d_q[1][31:0]} + {32'b0, d_q[0][63:32]};
      3'd2:    c_w = c_q + {32'b0, d_q[2][31:0]} + {32'b0, d_q[1][63:32]};
      3'd3:    c_w = c_q + {32'b0, d_q[3][31:0]} + {32'b0, d_q[2][63:32]};
      3'd4:    c_w = {32'b0, c_q[31:0] + {30'b0, d_q[4][1:0]}};
      default: c_w = c_q;
    endcase
  end

  assign fold_w = {30'b0, h_q[129:0]} + 160'({h_q[159:130], 2'b00} + {2'b00, h_q[159:130]});
  assign g_w    = h_q + 160'd5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q     <= '0;
      p_vld_q <= 1'b0;
      stat_q  <= '0;
    end else begin
      p_vld_q <= (cmd_i.op == pmac_pkg::OP_MUL);
      unique case (cmd_i.op)
        pmac_pkg::OP_LOAD: begin
          stat_q.nz   <= (n_w != 5'd0);
          stat_q.last <= in_i.last;
        end
        pmac_pkg::OP_RED:  h_q[{cmd_i.i, 5'b00000} +: 32] <= c_w[31:0];
        pmac_pkg::OP_FOLD: h_q <= fold_w;
        pmac_pkg::OP_SEL: begin
          if (g_w[159:130] != 30'd0) begin
            h_q <= g_w;
          end
        end
        pmac_pkg::OP_TAG:  h_q <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == pmac_pkg::OP_LOAD) begin
      blk_q <= {32'b0, data_w & mask_w} | pad_w;
    end
    if (cmd_i.op == pmac_pkg::OP_ADD) begin
      a_q <= h_q + blk_q;
      d_q <= '0;
    end else if (cmd_i.op == pmac_pkg::OP_D4) begin
      d_q[4] <= d_q[4] + {32'b0, d_q[3][63:32]};
    end else if (p_vld_q) begin
      d_q[p_dst_q] <= d_q[p_dst_q] + p_q;
    end
    if (cmd_i.op == pmac_pkg::OP_MUL) begin
      p_q     <= prod_w;
      p_dst_q <= cmd_i.j;
    end
    if (cmd_i.op == pmac_pkg::OP_RED) begin
      c_q <= {32'b0, c_w[63:32]};
    end
    if (cmd_i.op == pmac_pkg::OP_TAG) begin
      tag_q <= h_q[127:0] + {cfg_i.s_high, cfg_i.s_low};
    end
  end

  assign stat_o        = stat_q;
  assign tag_o.tag_low  = tag_q[63:0];
  assign tag_o.tag_high = tag_q[127:64];

endmodule

@@ rtl/pmac_ctrl.sv @@
// control state machine sequencing add, multiply, carry pass and tag finish
// depends on pmac_pkg
module pmac_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  pmac_pkg::stat_t  stat_i,
  output pmac_pkg::cmd_t   cmd_o,
  output logic             busy,
  output logic             done_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ADD   = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_DRAIN = 4'd3;
  localparam logic [3:0] S_D4    = 4'd4;
  localparam logic [3:0] S_RED   = 4'd5;
  localparam logic [3:0] S_FOLD1 = 4'd6;
  localparam logic [3:0] S_FOLD2 = 4'd7;
  localparam logic [3:0] S_SEL   = 4'd8;
  localparam logic [3:0] S_TAG   = 4'd9;

  logic [3:0] state_q, state_d;
  logic [2:0] i_q, i_d, j_q, j_d;
  logic       done_q, done_d;

  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    done_d    = 1'b0;
    cmd_o.op  = pmac_pkg::OP_NONE;
    cmd_o.i   = i_q;
    cmd_o.j   = j_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.op = pmac_pkg::OP_LOAD;
          state_d  = S_ADD;
        end
      end
      S_ADD: begin
        i_d = '0;
        j_d = '0;
        if (stat_i.nz) begin
          cmd_o.op = pmac_pkg::OP_ADD;
          state_d  = S_MUL;
        end else if (stat_i.last) begin
          state_d = S_FOLD1;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_MUL: begin
        cmd_o.op = pmac_pkg::OP_MUL;
        if (j_q == pmac_pkg::LIMB_TOP) begin
          state_d = S_DRAIN;
        end else if (i_q == pmac_pkg::LIMB_TOP) begin
          i_d = (j_q == 3'd3) ? pmac_pkg::LIMB_TOP : 3'd0;
          j_d = j_q + 3'd1;
        end else begin
          i_d = i_q + 3'd1;
        end
      end
      S_DRAIN: state_d = S_D4;
      S_D4: begin
        cmd_o.op = pmac_pkg::OP_D4;
        i_d      = '0;
        state_d  = S_RED;
      end
      S_RED: begin
        cmd_o.op = pmac_pkg::OP_RED;
        i_d      = i_q + 3'd1;
        if (i_q == pmac_pkg::LIMB_TOP) begin
          state_d = stat_i.last ? S_FOLD1 : S_IDLE;
        end
      end
      S_FOLD1: begin
        cmd_o.op = pmac_pkg::OP_FOLD;
        state_d  = S_FOLD2;
      end
      S_FOLD2: begin
        cmd_o.op = pmac_pkg::OP_FOLD;
        state_d  = S_SEL;
      end
      S_SEL: begin
        cmd_o.op = pmac_pkg::OP_SEL;
        state_d  = S_TAG;
      end
      S_TAG: begin
        cmd_o.op = pmac_pkg::OP_TAG;
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

@@ rtl/poly1305_mac_engine.sv @@
// poly1305 mac engine: one block at a time, taking start only while idle
// (load, add, 21 products on the shared 32x32 multiplier, drain, d4, 5 carry limbs)
// a last block adds two folds, select and tag; tag and strobe are registered at tag
// a zero-count block skips to idle, or to the folds when last; results cannot be stalled
// reset clears the key registers, the accumulator and the controller
// depends on pmac_pkg, pmac_regs, pmac_ctrl, pmac_dp
module poly1305_mac_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  pmac_pkg::in_t    in_data_i,
  output logic             done_o,
  output pmac_pkg::out_t   tag_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  pmac_pkg::cfg_t  cfg_w;
  pmac_pkg::cmd_t  cmd_w;
  pmac_pkg::stat_t stat_w;

  pmac_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg_w)
  );

  pmac_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat_w),
    .cmd_o  (cmd_w),
    .busy   (busy),
    .done_o (done_o)
  );

  pmac_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_data_i),
    .cfg_i  (cfg_w),
    .cmd_i  (cmd_w),
    .stat_o (stat_w),
    .tag_o  (tag_o)
  );

endmodule

@@ rtl/pmac_checker.sv @@
// port-level checker for the poly1305 mac engine, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module pmac_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic pready
);

  `PM_ASSERT(a_accept_busy, start && !busy |=> busy)
  `PM_ASSERT(a_done_idle, done_o |-> !busy)
  `PM_ASSERT(a_done_after_work, done_o |-> $past(busy))
  `PM_ASSERT(a_done_strobe, done_o |=> !done_o)
  `PM_ASSERT_ALWAYS(a_pready, pready)

endmodule

bind poly1305_mac_engine pmac_checker u_pmac_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .pready (pready)
);
